// ----- src/spkt_pkg.sv -----
// Package for the sorted pressed-key table: sizes, op and status codes and
// sequencer states. No dependencies; every other file imports it.
package spkt_pkg;

   localparam int MAX_KEYS    = 16;
   localparam int MAX_RESULTS = 16;
   localparam int LIST_MAX    = (MAX_KEYS < MAX_RESULTS) ? MAX_KEYS : MAX_RESULTS;
   localparam int IDX_W       = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
   localparam int CNT_W       = $clog2(MAX_KEYS + 1);

   localparam int OP_W     = 2;
   localparam int KEY_W    = 16;
   localparam int PCOUNT_W = 8;
   localparam int LIMIT_W  = 5;
   localparam int ACOUNT_W = 5;

   localparam logic [LIMIT_W-1:0]  LIMIT_RESET = LIMIT_W'(16);
   localparam logic [PCOUNT_W-1:0] PCOUNT_MAX  = '1;

   typedef enum logic [OP_W-1:0] {
      OP_UPDATE = 2'd0,
      OP_CLEAR  = 2'd1,
      OP_LIST   = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      STS_OK         = 2'd0,
      STS_NO_SPACE   = 2'd1,
      STS_NOT_ACTIVE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_SHIFT_UP,
      ST_SHIFT_DOWN,
      ST_LIST,
      ST_DONE
   } state_type;

endpackage

// ----- src/spkt_ifs.sv -----
// Request and response channel interfaces of the sorted pressed-key table.
// Depend on spkt_pkg for field widths.
interface spkt_req_if import spkt_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [KEY_W-1:0]  key_id;
   logic              pressed;

   modport source (output valid, op, key_id, pressed, input ready);
   modport sink   (input valid, op, key_id, pressed, output ready);
endinterface

interface spkt_rsp_if import spkt_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [1:0]          status;
   logic                changed;
   logic [KEY_W-1:0]    listed_id;
   logic                listed_valid;
   logic [ACOUNT_W-1:0] active_count;
   logic                last;

   modport source (output valid, status, changed, listed_id, listed_valid, active_count,
                   last, input ready);
   modport sink   (input valid, status, changed, listed_id, listed_valid, active_count,
                   last, output ready);
endinterface

// ----- src/sorted_pressed_key_table.sv -----
// Sorted pressed-key table: up to MAX_KEYS key IDs in ascending order, each with a
// saturating press count. One request is worked at a time; ready is high only while the
// sequencer is idle. The table has a single read port that the sequencer steps one entry
// per cycle: an update searches up to the key's slot, then on insert or removal shifts the
// entries from there to the end of the fill, and the done state then loads the response.
// A clear goes straight to the done state; a list emits one response per cycle per active
// entry (one for an empty table), slowed only by back-pressure. A finished response waits
// in the output register while the next request is taken. Depends on spkt_pkg and spkt_ifs.
module sorted_pressed_key_table import spkt_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   spkt_req_if.sink           req_chan,
   spkt_rsp_if.source         rsp_chan,
   input  logic               csr_wr_en,
   input  logic [LIMIT_W-1:0] csr_wr_data
);

   // table storage, no reset: entries at or above used_ff never affect a result
   logic [KEY_W-1:0]    ids_ff    [MAX_KEYS];
   logic [PCOUNT_W-1:0] counts_ff [MAX_KEYS];

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    used_ff, used_in;
   logic [CNT_W-1:0]    ptr_ff, ptr_in;
   logic [CNT_W-1:0]    slot_ff, slot_in;
   logic [LIMIT_W-1:0]  limit_ff;
   logic [KEY_W-1:0]    key_ff;
   logic                press_ff;
   status_type          status_ff, status_in;
   logic                changed_ff, changed_in;

   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic                rsp_changed_ff, rsp_changed_in;
   logic [KEY_W-1:0]    rsp_id_ff, rsp_id_in;
   logic                rsp_lvalid_ff, rsp_lvalid_in;
   logic [ACOUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                req_take;
   logic                out_free;
   logic [CNT_W-1:0]    limit_eff;
   logic [CNT_W-1:0]    list_n;
   logic [CNT_W-1:0]    rd_ptr;
   logic [IDX_W-1:0]    rd_idx;
   logic [KEY_W-1:0]    rd_id;
   logic [PCOUNT_W-1:0] rd_cnt;
   logic                at_end, stop, hit, list_last;

   logic                wr_en;
   logic [IDX_W-1:0]    wr_idx;
   logic [KEY_W-1:0]    wr_id;
   logic [PCOUNT_W-1:0] wr_cnt;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_take       = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   assign limit_eff = (int'(limit_ff) > MAX_KEYS) ? CNT_W'(MAX_KEYS) : CNT_W'(limit_ff);
   assign list_n    = (int'(used_ff) > LIST_MAX) ? CNT_W'(LIST_MAX) : used_ff;

   // single read port: address chosen by the sequencer step
   always_comb begin
      case (state_ff)
         ST_SHIFT_UP:   rd_ptr = ptr_ff - CNT_W'(1);
         ST_SHIFT_DOWN: rd_ptr = ptr_ff + CNT_W'(1);
         default:       rd_ptr = ptr_ff;
      endcase
   end

   assign rd_idx = (int'(rd_ptr) < MAX_KEYS) ? rd_ptr[IDX_W-1:0] : '0;
   assign rd_id  = ids_ff[rd_idx];
   assign rd_cnt = counts_ff[rd_idx];

   // shared compare unit
   assign at_end    = (ptr_ff == used_ff);
   assign stop      = at_end || (key_ff <= rd_id);
   assign hit       = !at_end && (key_ff == rd_id);
   assign list_last = (used_ff == '0) || (ptr_ff + CNT_W'(1) == list_n);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               case (req_chan.op)
                  OP_UPDATE: state_in = ST_SEARCH;
                  OP_CLEAR:  state_in = ST_DONE;
                  OP_LIST:   state_in = ST_LIST;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_SEARCH: begin
            if (stop) begin
               if (hit) begin
                  if (!press_ff && rd_cnt <= PCOUNT_W'(1)) state_in = ST_SHIFT_DOWN;
                  else                                      state_in = ST_DONE;
               end else if (press_ff && used_ff < limit_eff) begin
                  state_in = ST_SHIFT_UP;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SHIFT_UP: begin
            if (ptr_ff == slot_ff) state_in = ST_DONE;
         end
         ST_SHIFT_DOWN: begin
            if (!(ptr_ff + CNT_W'(1) < used_ff)) state_in = ST_DONE;
         end
         ST_LIST: begin
            if (out_free && list_last) state_in = ST_IDLE;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      used_in    = used_ff;
      ptr_in     = ptr_ff;
      slot_in    = slot_ff;
      status_in  = status_ff;
      changed_in = changed_ff;
      wr_en      = 1'b0;
      wr_idx     = ptr_ff[IDX_W-1:0];
      wr_id      = rd_id;
      wr_cnt     = rd_cnt;

      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_changed_in = rsp_changed_ff;
      rsp_id_in      = rsp_id_ff;
      rsp_lvalid_in  = rsp_lvalid_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_last_in    = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            ptr_in     = '0;
            status_in  = STS_OK;
            changed_in = 1'b0;
            if (req_take && req_chan.op == OP_CLEAR) begin
               changed_in = (used_ff != '0);
               used_in    = '0;
            end
         end
         ST_SEARCH: begin
            if (stop) begin
               slot_in = ptr_ff;
               if (hit) begin
                  if (press_ff) begin
                     wr_en  = 1'b1;
                     wr_cnt = (rd_cnt == PCOUNT_MAX) ? rd_cnt : rd_cnt + PCOUNT_W'(1);
                  end else if (rd_cnt > PCOUNT_W'(1)) begin
                     wr_en  = 1'b1;
                     wr_cnt = rd_cnt - PCOUNT_W'(1);
                  end
               end else if (press_ff) begin
                  if (used_ff < limit_eff) ptr_in    = used_ff;
                  else                     status_in = STS_NO_SPACE;
               end else begin
                  status_in = STS_NOT_ACTIVE;
               end
            end else begin
               ptr_in = ptr_ff + CNT_W'(1);
            end
         end
         ST_SHIFT_UP: begin
            wr_en = 1'b1;
            if (ptr_ff == slot_ff) begin
               // drop the new key into the gap
               wr_id      = key_ff;
               wr_cnt     = PCOUNT_W'(1);
               used_in    = used_ff + CNT_W'(1);
               changed_in = 1'b1;
            end else begin
               ptr_in = ptr_ff - CNT_W'(1);
            end
         end
         ST_SHIFT_DOWN: begin
            if (ptr_ff + CNT_W'(1) < used_ff) begin
               wr_en  = 1'b1;
               ptr_in = ptr_ff + CNT_W'(1);
            end else begin
               used_in    = used_ff - CNT_W'(1);
               changed_in = 1'b1;
            end
         end
         ST_LIST: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = STS_OK;
               rsp_changed_in = 1'b0;
               rsp_lvalid_in  = (used_ff != '0);
               rsp_id_in      = (used_ff != '0) ? rd_id : '0;
               rsp_count_in   = ACOUNT_W'(used_ff);
               rsp_last_in    = list_last;
               ptr_in         = ptr_ff + CNT_W'(1);
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_changed_in = changed_ff;
               rsp_lvalid_in  = 1'b0;
               rsp_id_in      = '0;
               rsp_count_in   = ACOUNT_W'(used_ff);
               rsp_last_in    = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) limit_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff         <= ptr_in;
      slot_ff        <= slot_in;
      status_ff      <= status_in;
      changed_ff     <= changed_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_changed_ff <= rsp_changed_in;
      rsp_id_ff      <= rsp_id_in;
      rsp_lvalid_ff  <= rsp_lvalid_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_last_ff    <= rsp_last_in;
      if (req_take) begin
         key_ff   <= req_chan.key_id;
         press_ff <= req_chan.pressed;
      end
      if (wr_en) begin
         ids_ff[wr_idx]    <= wr_id;
         counts_ff[wr_idx] <= wr_cnt;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.changed      = rsp_changed_ff;
   assign rsp_chan.listed_id    = rsp_id_ff;
   assign rsp_chan.listed_valid = rsp_lvalid_ff;
   assign rsp_chan.active_count = rsp_count_ff;
   assign rsp_chan.last         = rsp_last_ff;

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      int'(used_ff) <= MAX_KEYS)
      else $error("table fill beyond capacity");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      req_take && req_chan.op == OP_CLEAR |=> used_ff == '0)
      else $error("clear left entries in the table");

   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SHIFT_UP |-> used_ff < limit_eff && slot_ff <= ptr_ff)
      else $error("insert started without room");

   a_search_ptr: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SEARCH |-> ptr_ff <= used_ff)
      else $error("search ran past the fill");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_lvalid_ff |-> rsp_last_ff)
      else $error("non-list response without last mark");

endmodule

// ----- bench/tb_sorted_pressed_key_table.sv -----
// Self-checking bench for sorted_pressed_key_table: directed table, count saturation sweep
// and random phases over several key limits, checked against a tracking model (typed rows
// against their fixed responses). Depends on spkt_pkg, spkt_ifs and the block itself.
`timescale 1ns / 100ps

module tb_sorted_pressed_key_table import spkt_pkg::*; ();

   localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;
   localparam int              DRAIN_WAIT  = 2 * MAX_KEYS + 8;
   localparam int              IDLE_PCT    = 24;
   localparam int              PHASE_ITEMS = 28;
   localparam int              POOL_SIZE   = 24;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [KEY_W-1:0] key_id;
      logic             pressed;
   } key_req_type;

   typedef struct packed {
      logic [1:0]          status;
      logic                changed;
      logic [KEY_W-1:0]    listed_id;
      logic                listed_valid;
      logic [ACOUNT_W-1:0] active_count;
      logic                last;
   } key_rsp_type;

   typedef struct packed {
      key_req_type item;
      logic        typed;
      key_rsp_type want;
   } directed_row_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [LIMIT_W-1:0] csr_wr_data;

   spkt_req_if req_chan ();
   spkt_rsp_if rsp_chan ();

   sorted_pressed_key_table DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // tracking model of the table
   logic [KEY_W-1:0]    key_ids    [MAX_KEYS];
   logic [PCOUNT_W-1:0] key_counts [MAX_KEYS];
   int                  used_keys;
   logic [LIMIT_W-1:0]  key_limit;

   key_rsp_type      step_rsps [$];
   key_rsp_type      expected_key_rsps [$];
   directed_row_type directed_rows [$];
   logic [KEY_W-1:0] key_pool [POOL_SIZE];

   int fail_count;
   bit steady_flow;

   initial begin
      clock = 1'b0;
   end

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic key_rsp_type pack_rsp(input logic [1:0] st, input logic chg,
                                            input logic [KEY_W-1:0] id, input logic vld,
                                            input logic fin);
      key_rsp_type r;
      r.status       = st;
      r.changed      = chg;
      r.listed_id    = id;
      r.listed_valid = vld;
      r.active_count = ACOUNT_W'(used_keys);
      r.last         = fin;
      return r;
   endfunction

   task automatic track_key_table(input key_req_type item);
      int         i;
      int         slot;
      int         prior_used;
      int         cap;
      status_type sts;
      step_rsps.delete();
      prior_used = used_keys;
      cap        = (int'(key_limit) > MAX_KEYS) ? MAX_KEYS : int'(key_limit);
      sts        = STS_OK;
      if (item.op == OP_CLEAR) begin
         for (i = 0; i < MAX_KEYS; i++) begin
            key_ids[i]    = '0;
            key_counts[i] = '0;
         end
         used_keys = 0;
         step_rsps.push_back(pack_rsp(STS_OK, prior_used != 0, '0, 1'b0, 1'b1));
      end else if (item.op == OP_LIST) begin
         if (used_keys == 0)
            step_rsps.push_back(pack_rsp(STS_OK, 1'b0, '0, 1'b0, 1'b1));
         for (i = 0; i < used_keys && i < LIST_MAX; i++)
            step_rsps.push_back(pack_rsp(STS_OK, 1'b0, key_ids[i], 1'b1,
                                         i + 1 == used_keys || i + 1 == LIST_MAX));
      end else if (item.op == OP_UPDATE) begin
         slot = 0;
         while (slot < used_keys && item.key_id > key_ids[slot])
            slot++;
         if (slot < used_keys && key_ids[slot] == item.key_id) begin
            if (item.pressed) begin
               if (key_counts[slot] != PCOUNT_MAX)
                  key_counts[slot] = key_counts[slot] + 1'b1;
            end else begin
               key_counts[slot] = key_counts[slot] - 1'b1;
               // close the gap once the last press is gone
               if (key_counts[slot] == '0) begin
                  for (i = slot; i + 1 < used_keys; i++) begin
                     key_ids[i]    = key_ids[i + 1];
                     key_counts[i] = key_counts[i + 1];
                  end
                  used_keys--;
                  key_ids[used_keys]    = '0;
                  key_counts[used_keys] = '0;
               end
            end
         end else if (item.pressed) begin
            if (used_keys >= cap) begin
               sts = STS_NO_SPACE;
            end else begin
               for (i = used_keys; i > slot; i--) begin
                  key_ids[i]    = key_ids[i - 1];
                  key_counts[i] = key_counts[i - 1];
               end
               key_ids[slot]    = item.key_id;
               key_counts[slot] = 8'd1;
               used_keys++;
            end
         end else begin
            sts = STS_NOT_ACTIVE;
         end
         step_rsps.push_back(pack_rsp(sts, prior_used != used_keys, '0, 1'b0, 1'b1));
      end
   endtask

   // hold the request until it is taken, then log what it should produce
   task automatic send_request(input key_req_type item, input logic typed,
                               input key_rsp_type want);
      while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid   = 1'b1;
      req_chan.op      = item.op;
      req_chan.key_id  = item.key_id;
      req_chan.pressed = item.pressed;
      do @(posedge clock); while (!req_chan.ready);
      track_key_table(item);
      if (typed)
         expected_key_rsps.push_back(want);
      else
         foreach (step_rsps[k])
            expected_key_rsps.push_back(step_rsps[k]);
      @(negedge clock);
   endtask

   task automatic drain_block();
      req_chan.valid = 1'b0;
      while (expected_key_rsps.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] value);
      drain_block();
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(posedge clock);
      key_limit = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   function automatic void add_row(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] id,
                                   input logic pressed, input logic typed,
                                   input status_type st, input logic chg, input int cnt);
      directed_row_type row;
      row.item.op      = op;
      row.item.key_id  = id;
      row.item.pressed = pressed;
      row.typed        = typed;
      row.want         = '{status: st, changed: chg, listed_id: '0, listed_valid: 1'b0,
                           active_count: ACOUNT_W'(cnt), last: 1'b1};
      directed_rows.push_back(row);
   endfunction

   function automatic key_req_type random_key_req();
      key_req_type r;
      int          pick;
      pick      = $urandom_range(99);
      r.op      = OP_UPDATE;
      r.key_id  = key_pool[$urandom_range(POOL_SIZE - 1)];
      r.pressed = ($urandom_range(99) < 65);
      if (pick < 3) begin
         r.op     = OP_UNUSED;
         r.key_id = KEY_W'($urandom);
      end else if (pick < 6) begin
         r.op = OP_CLEAR;
      end else if (pick < 16) begin
         r.op = OP_LIST;
      end else if (pick < 22) begin
         r.key_id  = KEY_W'($urandom);
         r.pressed = 1'($urandom_range(1));
      end
      return r;
   endfunction

   always @(negedge clock) begin
      if (!reset)
         rsp_chan.ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      key_rsp_type seen;
      key_rsp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         seen = '{status: rsp_chan.status, changed: rsp_chan.changed,
                  listed_id: rsp_chan.listed_id, listed_valid: rsp_chan.listed_valid,
                  active_count: rsp_chan.active_count, last: rsp_chan.last};
         if (expected_key_rsps.size() == 0) begin
            fail_count++;
            $display({"%0t: response with none expected: ",
                      "sts %0d chg %0b id %h vld %0b cnt %0d last %0b"},
                     $time, seen.status, seen.changed, seen.listed_id, seen.listed_valid,
                     seen.active_count, seen.last);
         end else begin
            want = expected_key_rsps.pop_front();
            if (seen !== want) begin
               fail_count++;
               $display({"%0t: expected sts %0d chg %0b id %h vld %0b cnt %0d last %0b, ",
                         "actual sts %0d chg %0b id %h vld %0b cnt %0d last %0b"},
                        $time, want.status, want.changed, want.listed_id,
                        want.listed_valid, want.active_count, want.last,
                        seen.status, seen.changed, seen.listed_id, seen.listed_valid,
                        seen.active_count, seen.last);
            end
         end
      end
   end

   initial begin
      #8_000_000;
      $display("status: fail");
      $finish;
   end

   initial begin
      logic [LIMIT_W-1:0] phase_limits [8];
      key_req_type        item;
      key_rsp_type        no_rsp;
      int                 n;
      int                 p;
      int                 i;

      phase_limits = '{5'd16, 5'd1, 5'd16, 5'd3, 5'd0, 5'd8, 5'd31, 5'd5};
      no_rsp       = '0;
      fail_count   = 0;
      steady_flow  = 1'b0;
      reset        = 1'b1;
      csr_wr_en    = 1'b0;
      csr_wr_data  = '0;
      req_chan.valid   = 1'b0;
      req_chan.op      = OP_UPDATE;
      req_chan.key_id  = '0;
      req_chan.pressed = 1'b0;
      rsp_chan.ready   = 1'b0;
      for (i = 0; i < MAX_KEYS; i++) begin
         key_ids[i]    = '0;
         key_counts[i] = '0;
      end
      used_keys = 0;
      key_limit = LIMIT_RESET;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table, run at the reset limit
      add_row(OP_LIST,   16'h0000, 1'b0, 1'b1, STS_OK,         1'b0, 0);
      add_row(OP_UPDATE, 16'h1234, 1'b0, 1'b1, STS_NOT_ACTIVE, 1'b0, 0);
      add_row(OP_UPDATE, 16'hFFFF, 1'b1, 1'b1, STS_OK,         1'b1, 1);
      add_row(OP_UPDATE, 16'h0000, 1'b1, 1'b1, STS_OK,         1'b1, 2);
      add_row(OP_UPDATE, 16'h8000, 1'b1, 1'b1, STS_OK,         1'b1, 3);
      add_row(OP_UPDATE, 16'h5555, 1'b1, 1'b0, STS_OK,         1'b0, 0);
      add_row(OP_UPDATE, 16'hAAAA, 1'b1, 1'b0, STS_OK,         1'b0, 0);
      add_row(OP_UPDATE, 16'h8000, 1'b1, 1'b1, STS_OK,         1'b0, 5);
      add_row(OP_LIST,   16'h0000, 1'b0, 1'b0, STS_OK,         1'b0, 0);
      add_row(OP_UPDATE, 16'h8000, 1'b0, 1'b1, STS_OK,         1'b0, 5);
      add_row(OP_UPDATE, 16'h8000, 1'b0, 1'b1, STS_OK,         1'b1, 4);
      add_row(OP_UPDATE, 16'h0000, 1'b0, 1'b1, STS_OK,         1'b1, 3);
      add_row(OP_UPDATE, 16'h0000, 1'b0, 1'b1, STS_NOT_ACTIVE, 1'b0, 3);
      add_row(OP_UNUSED, 16'h1234, 1'b1, 1'b0, STS_OK,         1'b0, 0);
      add_row(OP_LIST,   16'hFFFF, 1'b1, 1'b0, STS_OK,         1'b0, 0);
      add_row(OP_CLEAR,  16'h0000, 1'b0, 1'b1, STS_OK,         1'b1, 0);
      add_row(OP_CLEAR,  16'hFFFF, 1'b1, 1'b1, STS_OK,         1'b0, 0);
      add_row(OP_UPDATE, 16'h7FFF, 1'b1, 1'b1, STS_OK,         1'b1, 1);
      add_row(OP_UPDATE, 16'h7FFE, 1'b1, 1'b0, STS_OK,         1'b0, 0);
      add_row(OP_LIST,   16'h0000, 1'b0, 1'b0, STS_OK,         1'b0, 0);
      foreach (directed_rows[r])
         send_request(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want);

      // drive one key past count saturation, then step it back down
      write_limit(5'd31);
      item = '{op: OP_CLEAR, key_id: 16'h0000, pressed: 1'b0};
      send_request(item, 1'b0, no_rsp);
      item = '{op: OP_UPDATE, key_id: 16'h00FF, pressed: 1'b1};
      repeat (257) send_request(item, 1'b0, no_rsp);
      item.pressed = 1'b0;
      repeat (2) send_request(item, 1'b0, no_rsp);

      for (p = 0; p < 8; p++) begin
         write_limit(phase_limits[p]);
         steady_flow = (p == 2);
         key_pool[0] = 16'h0000;
         key_pool[1] = 16'hFFFF;
         for (i = 2; i < POOL_SIZE; i++)
            key_pool[i] = KEY_W'($urandom);
         n = 0;
         while (n < PHASE_ITEMS) begin
            item = random_key_req();
            send_request(item, 1'b0, no_rsp);
            if (item.op != OP_UNUSED)
               n++;
         end
      end
      steady_flow = 1'b0;

      drain_block();
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ----- filelist.f -----
src/spkt_pkg.sv
src/spkt_ifs.sv
src/sorted_pressed_key_table.sv
bench/tb_sorted_pressed_key_table.sv
